### rtl/core/accel_tilt_measurement_model_defines.svh
// assertion macros for the tilt measurement rtl
`ifndef ACCEL_TILT_MEASUREMENT_MODEL_DEFINES_SVH
`define ACCEL_TILT_MEASUREMENT_MODEL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ATM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("atm assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ATM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("atm assertion failed");

`endif

### rtl/core/atm_pkg.sv
// types, constants and helpers for the tilt measurement pipeline
`default_nettype none

package atm_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int ANGLE_W = 16;
	localparam int PHASE_W = 32;
	localparam int COORD_W = 19;
	localparam int TRIG_W = 18;
	localparam int TRIG_FRAC = 16;
	localparam int TRIG_ONE = 65536;
	localparam int CORDIC_START = 39797;
	localparam int GRAVITY_W = 17;
	localparam logic [GRAVITY_W-1:0] GRAVITY_RESET = 17'd40168;
	localparam int ACCEL_W = 18;
	localparam int INNOV_W = 19;
	localparam int JAC_W = 18;
	localparam int PROD_W = 2 * TRIG_W;
	localparam int ACCEL_ALL_W = 3 * ACCEL_W;

	localparam int S_FIELDS_W = 2 * ANGLE_W + 3 * ACCEL_W;
	localparam int S_TDATA_W = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 3 * INNOV_W + 5 * JAC_W;
	localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

	localparam int CORDIC_STEPS = 16;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int CORDIC_LAT = CORDIC_STAGES + 2;

	localparam logic [PHASE_W-1:0] PHASE_KEEP =
		~((PHASE_W'(1) << (PHASE_W - ANGLE_BITS)) - PHASE_W'(1));

	localparam logic [PHASE_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [PHASE_W-1:0] phase_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACCEL_W-1:0] accel_t;
	typedef logic signed [INNOV_W-1:0] innov_t;
	typedef logic signed [JAC_W-1:0] jac_t;

	// rounded trig product back to the value format
	function automatic jac_t trig_round(prod_t p);
		prod_t r;
		r = (p + prod_t'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
		return r[JAC_W-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/core/atm_cordic.sv
// pipelined sine and cosine of one binary angle, two rotations per stage
`default_nettype none

module atm_cordic import atm_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  angle_t angle,
	output trig_t  sin_out,
	output trig_t  cos_out
);

	coord_t x_s [CORDIC_STAGES+1];
	coord_t y_s [CORDIC_STAGES+1];
	phase_t z_s [CORDIC_STAGES+1];
	logic   flip_s [CORDIC_STAGES+1];

	trig_t  sin_out_s;
	trig_t  cos_out_s;

	logic [PHASE_W-1:0] phase;
	logic               flip;

	// fold the left half plane onto the right one
	assign phase = {angle, {(PHASE_W - ANGLE_W){1'b0}}} & PHASE_KEEP;
	assign flip  = phase[PHASE_W-1] ^ phase[PHASE_W-2];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= coord_t'(CORDIC_START);
			y_s[0]    <= '0;
			z_s[0]    <= phase_t'({phase[PHASE_W-1] ^ flip, phase[PHASE_W-2:0]});
			flip_s[0] <= flip;
		end
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		coord_t x_nxt;
		coord_t y_nxt;
		phase_t z_nxt;

		always_comb begin : p_rot
			coord_t x, y, dx, dy;
			phase_t z;
			x = x_s[k];
			y = y_s[k];
			z = z_s[k];
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				dx = y >>> (k * STEPS_PER_STAGE + j);
				dy = x >>> (k * STEPS_PER_STAGE + j);
				if (!z[PHASE_W-1]) begin
					x = x - dx;
					y = y + dy;
					z = z - phase_t'(ATAN_TURN[k * STEPS_PER_STAGE + j]);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + phase_t'(ATAN_TURN[k * STEPS_PER_STAGE + j]);
				end
			end
			x_nxt = x;
			y_nxt = y;
			z_nxt = z;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= x_nxt;
				y_s[k+1]    <= y_nxt;
				z_s[k+1]    <= z_nxt;
				flip_s[k+1] <= flip_s[k];
			end
		end
	end

	// undo the fold and clamp to one
	function automatic trig_t unfold(coord_t v, logic f);
		coord_t r;
		r = f ? -v : v;
		if (r > coord_t'(TRIG_ONE))
			r = coord_t'(TRIG_ONE);
		else if (r < -coord_t'(TRIG_ONE))
			r = -coord_t'(TRIG_ONE);
		return r[TRIG_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sin_out_s <= unfold(y_s[CORDIC_STAGES], flip_s[CORDIC_STAGES]);
			cos_out_s <= unfold(x_s[CORDIC_STAGES], flip_s[CORDIC_STAGES]);
		end
	end

	assign sin_out = sin_out_s;
	assign cos_out = cos_out_s;

endmodule

`default_nettype wire

### rtl/core/accel_tilt_measurement_model.sv
// Accelerometer tilt measurement model: predicts gravity from roll and pitch
// and gives the innovation and the nonzero measurement Jacobian entries.
// One request is taken every cycle unless the output stalls; each result passes
// through the two 16-rotation CORDIC lanes at two rotations per stage, with fold
// and clamp, then three multiply and round stages. When the output register is
// full and not taken, the whole pipeline holds. The user writes gravity through
// cfg_wr_en and cfg_wr_data only while the block is idle; nothing enforces it.
`default_nettype none
`include "accel_tilt_measurement_model_defines.svh"

module accel_tilt_measurement_model import atm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [GRAVITY_W-1:0] cfg_wr_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// roll_angle, pitch_angle, accel_x, accel_y, accel_z, zero fill
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// innov_x, innov_y, innov_z, jac_x_pitch, jac_y_roll, jac_y_pitch,
	// jac_z_roll, jac_z_pitch, zero fill
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic [GRAVITY_W-1:0]   gravity_q;
	logic                   advance;
	logic [CORDIC_LAT-1:0]  vld_s;
	logic [ACCEL_ALL_W-1:0] accel_s [CORDIC_LAT];

	trig_t sin_roll, cos_roll, sin_pitch, cos_pitch;
	trig_t g_ext;

	logic                   vld_s11;
	prod_t                  prod_cp_s11, prod_sp_s11;
	trig_t                  sr_s11, cr_s11;
	logic [ACCEL_ALL_W-1:0] accel_s11;

	jac_t                   gc, gs;
	logic                   vld_s12;
	jac_t                   gc_s12, gs_s12;
	prod_t                  p_srgc_s12, p_crgc_s12, p_srgs_s12, p_crgs_s12;
	logic [ACCEL_ALL_W-1:0] accel_s12;

	jac_t                   hy, hz, t_rs, t_rc;
	accel_t                 ax, ay, az;
	innov_t                 innov_x, innov_y, innov_z;
	logic [M_TDATA_W-1:0]   out_data;

	logic                   out_valid_q;
	logic [M_TDATA_W-1:0]   out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RESET;
		end else if (cfg_wr_en) begin
			gravity_q <= cfg_wr_data;
		end
	end

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = advance;

	atm_cordic u_cordic_roll (
		.clk     (clk),
		.en      (advance),
		.angle   (angle_t'(s_axis_tdata[ANGLE_W-1:0])),
		.sin_out (sin_roll),
		.cos_out (cos_roll)
	);

	atm_cordic u_cordic_pitch (
		.clk     (clk),
		.en      (advance),
		.angle   (angle_t'(s_axis_tdata[2*ANGLE_W-1:ANGLE_W])),
		.sin_out (sin_pitch),
		.cos_out (cos_pitch)
	);

	// valid bits alongside the cordic lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			vld_s11     <= 1'b0;
			vld_s12     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			vld_s       <= {vld_s[CORDIC_LAT-2:0], s_axis_tvalid};
			vld_s11     <= vld_s[CORDIC_LAT-1];
			vld_s12     <= vld_s11;
			out_valid_q <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accel_s[0] <= s_axis_tdata[2*ANGLE_W +: ACCEL_ALL_W];
			for (int k = 1; k < CORDIC_LAT; k++)
				accel_s[k] <= accel_s[k-1];
		end
	end

	assign g_ext = trig_t'({1'b0, gravity_q});

	// gravity times pitch terms
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_cp_s11 <= prod_t'(cos_pitch) * prod_t'(g_ext);
			prod_sp_s11 <= prod_t'(sin_pitch) * prod_t'(g_ext);
			sr_s11      <= sin_roll;
			cr_s11      <= cos_roll;
			accel_s11   <= accel_s[CORDIC_LAT-1];
		end
	end

	assign gc = trig_round(prod_cp_s11);
	assign gs = trig_round(prod_sp_s11);

	// roll terms
	always_ff @(posedge clk) begin
		if (advance) begin
			gc_s12     <= gc;
			gs_s12     <= gs;
			p_srgc_s12 <= prod_t'(sr_s11) * prod_t'(gc);
			p_crgc_s12 <= prod_t'(cr_s11) * prod_t'(gc);
			p_srgs_s12 <= prod_t'(sr_s11) * prod_t'(gs);
			p_crgs_s12 <= prod_t'(cr_s11) * prod_t'(gs);
			accel_s12  <= accel_s11;
		end
	end

	always_comb begin
		hy   = trig_round(p_srgc_s12);
		hz   = trig_round(p_crgc_s12);
		t_rs = trig_round(p_srgs_s12);
		t_rc = trig_round(p_crgs_s12);
		ax   = accel_t'(accel_s12[ACCEL_W-1:0]);
		ay   = accel_t'(accel_s12[2*ACCEL_W-1:ACCEL_W]);
		az   = accel_t'(accel_s12[3*ACCEL_W-1:2*ACCEL_W]);
		innov_x = innov_t'(ax) + innov_t'(gs_s12);
		innov_y = innov_t'(ay) - innov_t'(hy);
		innov_z = innov_t'(az) - innov_t'(hz);
		out_data = {
			{(M_TDATA_W - M_FIELDS_W){1'b0}},
			jac_t'(-t_rc),
			jac_t'(-hy),
			jac_t'(-t_rs),
			hz,
			jac_t'(-gc_s12),
			innov_z,
			innov_y,
			innov_x
		};
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= out_data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`ATM_ASSERT_IMP(a_stall_blocks_input, out_valid_q && !m_axis_tready, !s_axis_tready)
	`ATM_ASSERT_NXT(a_request_enters, s_axis_tvalid && s_axis_tready, vld_s[0])
	`ATM_ASSERT_NXT(a_drain_empty, m_axis_tvalid && m_axis_tready && !vld_s12, !m_axis_tvalid)
	`ATM_ASSERT_IMP(a_cos_roll_range, vld_s[CORDIC_LAT-1],
		(cos_roll <= trig_t'(TRIG_ONE)) && (cos_roll >= -trig_t'(TRIG_ONE)))

endmodule

`default_nettype wire
